// ===== rtl/crc_rx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc_rx_pkg
// Shared types, constants and the byte-wide CRC update for the frame receiver.
// ----------------------------------------------------------------------------
package crc_rx_pkg;

  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned BYTE_W      = 8;
  // Two payload banks so one frame can drain while the next one is received.
  localparam int unsigned RAM_DEPTH   = 2 * MAX_PAYLOAD;
  localparam int unsigned ADDR_W      = IDX_W + 1;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned TDATA_W     = 32;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'b1;

  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ID,
    PH_LEN,
    PH_DATA,
    PH_CHECK
  } parse_phase_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SHOW
  } back_state_e;

  typedef struct packed {
    logic              bank;
    logic [BYTE_W-1:0] id;
    logic [LEN_W-1:0]  length;
  } frame_desc_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // CRC-16/CCITT-FALSE update with one byte, MSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [BYTE_W-1:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/crc_rx_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc_rx_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module crc_rx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/crc_rx_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc_rx_front
// Frame parser: hunts for the start byte, checks the length, stores the
// payload into the current bank and checks the CRC. A good frame is handed
// on as a descriptor and the bank flips.
// ----------------------------------------------------------------------------
module crc_rx_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [crc_rx_pkg::BYTE_W-1:0] cfg_start_byte_i,
  input  wire logic [crc_rx_pkg::LEN_W-1:0]  cfg_max_length_i,
  input  wire logic                         rx_valid_i,
  output logic                              rx_ready_o,
  input  wire logic [crc_rx_pkg::BYTE_W-1:0] rx_byte_i,
  input  wire crc_rx_pkg::queue_stat_t      q_stat_i,
  output crc_rx_pkg::ram_wr_t               ram_wr_o,
  output logic                              push_o,
  output crc_rx_pkg::frame_desc_t           desc_o
);
  import crc_rx_pkg::*;

  parse_phase_e      phase_q, phase_d;
  logic [LEN_W-1:0]  count_q, count_d;
  logic              crc_cnt_q, crc_cnt_d;
  logic [BYTE_W-1:0] id_q, id_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [15:0]       crc_q, crc_d;
  logic [BYTE_W-1:0] rx_lo_q, rx_lo_d;
  logic              bank_q, bank_d;
  logic [LEN_W-1:0]  limit;
  logic              accept;

  assign rx_ready_o = !q_stat_i.full;
  assign accept     = rx_valid_i && rx_ready_o;
  assign limit      = (cfg_max_length_i < LEN_W'(MAX_PAYLOAD)) ? cfg_max_length_i
                                                                : LEN_W'(MAX_PAYLOAD);
  assign desc_o     = '{bank: bank_q, id: id_q, length: len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      count_q   <= '0;
      crc_cnt_q <= 1'b0;
      id_q      <= '0;
      len_q     <= '0;
      crc_q     <= CRC_INIT;
      rx_lo_q   <= '0;
      bank_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      crc_cnt_q <= crc_cnt_d;
      id_q      <= id_d;
      len_q     <= len_d;
      crc_q     <= crc_d;
      rx_lo_q   <= rx_lo_d;
      bank_q    <= bank_d;
    end
  end

  always_comb begin
    phase_d       = phase_q;
    count_d       = count_q;
    crc_cnt_d     = crc_cnt_q;
    id_d          = id_q;
    len_d         = len_q;
    crc_d         = crc_q;
    rx_lo_d       = rx_lo_q;
    bank_d        = bank_q;
    push_o        = 1'b0;
    ram_wr_o.we   = 1'b0;
    ram_wr_o.addr = {bank_q, count_q[IDX_W-1:0]};
    ram_wr_o.data = rx_byte_i;
    if (accept) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == cfg_start_byte_i) begin
            crc_d   = crc_feed(CRC_INIT, rx_byte_i);
            phase_d = PH_ID;
          end
        end
        PH_ID: begin
          id_d    = rx_byte_i;
          crc_d   = crc_feed(crc_q, rx_byte_i);
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          // The rejected length byte is consumed and not taken as a start byte.
          if (rx_byte_i == '0 || rx_byte_i > {1'b0, limit}) begin
            phase_d = PH_HUNT;
          end else begin
            len_d   = rx_byte_i[LEN_W-1:0];
            crc_d   = crc_feed(crc_q, rx_byte_i);
            count_d = '0;
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          ram_wr_o.we = 1'b1;
          crc_d       = crc_feed(crc_q, rx_byte_i);
          count_d     = count_q + LEN_W'(1);
          if (count_d >= len_q) begin
            crc_cnt_d = 1'b0;
            phase_d   = PH_CHECK;
          end
        end
        PH_CHECK: begin
          if (!crc_cnt_q) begin
            rx_lo_d   = rx_byte_i;
            crc_cnt_d = 1'b1;
          end else begin
            // The CRC arrives low byte first.
            if ({rx_byte_i, rx_lo_q} == crc_q) begin
              push_o = 1'b1;
              bank_d = !bank_q;
            end
            crc_cnt_d = 1'b0;
            phase_d   = PH_HUNT;
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/crc_rx_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc_rx_queue
// Two-entry queue of accepted frame descriptors between parser and emitter.
// ----------------------------------------------------------------------------
module crc_rx_queue (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  input  wire crc_rx_pkg::frame_desc_t desc_i,
  input  wire logic                    pop_i,
  output crc_rx_pkg::frame_desc_t      head_o,
  output crc_rx_pkg::queue_stat_t      stat_o
);
  import crc_rx_pkg::*;

  frame_desc_t entry_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q, cnt_d;

  assign head_o       = entry_q[rptr_q];
  assign stat_o.full  = (cnt_q == QUEUE_DEPTH);
  assign stat_o.empty = (cnt_q == 2'd0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= desc_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/crc_rx_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc_rx_back
// Frame emitter: walks the payload bank of the head descriptor and presents
// one result per payload byte from an output register.
// ----------------------------------------------------------------------------
module crc_rx_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire crc_rx_pkg::frame_desc_t       head_i,
  input  wire crc_rx_pkg::queue_stat_t       q_stat_i,
  output logic                               pop_o,
  output logic [crc_rx_pkg::ADDR_W-1:0]      raddr_o,
  input  wire logic [crc_rx_pkg::BYTE_W-1:0] rdata_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [crc_rx_pkg::BYTE_W-1:0]      frame_id_o,
  output logic [crc_rx_pkg::LEN_W-1:0]       frame_length_o,
  output logic [crc_rx_pkg::IDX_W-1:0]       byte_index_o,
  output logic [crc_rx_pkg::BYTE_W-1:0]      payload_byte_o,
  output logic                               last_o
);
  import crc_rx_pkg::*;

  back_state_e       state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              valid_q, valid_d;
  logic              load;
  logic [BYTE_W-1:0] id_q;
  logic [LEN_W-1:0]  len_q;
  logic [IDX_W-1:0]  oidx_q;
  logic [BYTE_W-1:0] data_q;
  logic              last_q;

  // The read address follows the next index so the registered read lines up.
  assign raddr_o        = {head_i.bank, idx_d};
  assign out_valid_o    = valid_q;
  assign frame_id_o     = id_q;
  assign frame_length_o = len_q;
  assign byte_index_o   = oidx_q;
  assign payload_byte_o = data_q;
  assign last_o         = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      id_q   <= head_i.id;
      len_q  <= head_i.length;
      oidx_q <= idx_q;
      data_q <= rdata_i;
      last_q <= ({1'b0, idx_q} + LEN_W'(1)) == head_i.length;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    valid_d = valid_q;
    load    = 1'b0;
    pop_o   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          idx_d   = '0;
          state_d = BK_READ;
        end
      end
      BK_READ: begin
        load    = 1'b1;
        valid_d = 1'b1;
        state_d = BK_SHOW;
      end
      BK_SHOW: begin
        if (out_ready_i) begin
          valid_d = 1'b0;
          if (last_q) begin
            pop_o   = 1'b1;
            state_d = BK_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = BK_READ;
          end
        end
      end
      default: begin
        valid_d = 1'b0;
        state_d = BK_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/crc_checked_frame_receiver_unit.sv =====
`default_nettype none
// Input: one byte per cycle while the frame queue has room; the parser stalls
// only when two checked frames are still waiting to be drained.
// Output: a good frame's first result shows once its descriptor is queued, the emitter has
// left idle and the registered RAM read is loaded; the next is read once the last is taken.
// Reset clears the parser, queue, emitter and configuration (start byte 0xAA,
// limit 64); the payload RAM is not cleared.
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver_unit
// Length-prefixed frame receiver with CRC-16/CCITT-FALSE check; parser and
// emitter are decoupled by a descriptor queue and a two-bank payload RAM.
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [crc_rx_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [crc_rx_pkg::BYTE_W-1:0]    cfg_wdata_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [crc_rx_pkg::BYTE_W-1:0]    s_axis_tdata,  // rx_byte
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // frame_id[7:0], frame_length[14:8], byte_index[20:15], payload_byte[28:21], zeros
  output logic [crc_rx_pkg::TDATA_W-1:0]        m_axis_tdata,
  output logic                                  m_axis_tlast
);
  import crc_rx_pkg::*;

  logic [BYTE_W-1:0] start_byte_q;
  logic [LEN_W-1:0]  max_length_q;
  ram_wr_t           ram_wr;
  logic [ADDR_W-1:0] raddr;
  logic [BYTE_W-1:0] rdata;
  logic              q_push, q_pop;
  frame_desc_t       push_desc, head_desc;
  queue_stat_t       q_stat;
  logic [BYTE_W-1:0] frame_id;
  logic [LEN_W-1:0]  frame_length;
  logic [IDX_W-1:0]  byte_index;
  logic [BYTE_W-1:0] payload_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= 8'hAA;
      max_length_q <= LEN_W'(MAX_PAYLOAD);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_START_BYTE: start_byte_q <= cfg_wdata_i;
        CFG_MAX_LENGTH: max_length_q <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  crc_rx_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_start_byte_i (start_byte_q),
    .cfg_max_length_i (max_length_q),
    .rx_valid_i       (s_axis_tvalid),
    .rx_ready_o       (s_axis_tready),
    .rx_byte_i        (s_axis_tdata),
    .q_stat_i         (q_stat),
    .ram_wr_o         (ram_wr),
    .push_o           (q_push),
    .desc_o           (push_desc)
  );

  crc_rx_ram #(
    .Width (BYTE_W),
    .Depth (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  crc_rx_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .desc_i (push_desc),
    .pop_i  (q_pop),
    .head_o (head_desc),
    .stat_o (q_stat)
  );

  crc_rx_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head_desc),
    .q_stat_i       (q_stat),
    .pop_o          (q_pop),
    .raddr_o        (raddr),
    .rdata_i        (rdata),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .frame_id_o     (frame_id),
    .frame_length_o (frame_length),
    .byte_index_o   (byte_index),
    .payload_byte_o (payload_byte),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, payload_byte, byte_index, frame_length, frame_id};

`ifndef SYNTH
  // A checked frame is never handed to a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_stat.full)
    else $error("descriptor pushed into full queue");

  // The emitter only retires a frame that is queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_stat.empty)
    else $error("descriptor popped from empty queue");

  // A shown result always belongs to a queued frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni) m_axis_tvalid |-> !q_stat.empty)
    else $error("result shown without a queued frame");

  // After the last result of a frame is taken the output valid drops before any further result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("result shown directly after frame end");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_crc_checked_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// tb_crc_checked_frame_receiver_unit
// Self-checking bench for the CRC-checked frame receiver. A short table of
// frames covers the corner cases. Random phases follow, each with its own
// start byte and length limit. Every request that leaves the block is
// checked, field by field, against a frame parser kept inside the bench.
// ----------------------------------------------------------------------------
module tb_crc_checked_frame_receiver_unit;
  import crc_rx_pkg::*;

  localparam int RESET_CYCLES    = 12;
  localparam int ITEM_TARGET     = 410;
  localparam int SETTLE_CYCLES   = 16;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int MAX_PRINTS      = 40;
  localparam int DIRECTED_ROWS   = 26;

  typedef struct packed {
    logic [7:0] frame_id;
    logic [6:0] frame_length;
    logic [5:0] byte_index;
    logic [7:0] payload_byte;
    logic       last_flag;
  } payload_beat_t;

  typedef enum logic [2:0] {
    ROW_BYTE,
    ROW_CRC_LO,
    ROW_CRC_HI,
    ROW_CRC_BAD,
    ROW_SET_LIMIT
  } row_kind_e;

  typedef struct {
    row_kind_e     kind;
    logic [7:0]    value;
    int            typed_n;     // -1: the parser below decides
    payload_beat_t typed_beat;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [BYTE_W-1:0]    cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [BYTE_W-1:0]    s_axis_tdata;   // rx_byte
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // frame_id, frame_length, byte_index, payload_byte, zero padding
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic                 m_axis_tlast;

  crc_checked_frame_receiver_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Parser copy held by the bench.
  logic [7:0]   cfg_start;
  logic [6:0]   cfg_max;
  parse_phase_e prs_phase;
  logic [6:0]   prs_count;
  logic         prs_crc_half;
  logic [7:0]   prs_id;
  logic [6:0]   prs_len;
  logic [15:0]  prs_crc;
  logic [15:0]  prs_rx_crc;
  logic [7:0]   prs_store [MAX_PAYLOAD];

  payload_beat_t fresh_beats[$];
  payload_beat_t awaited_beats[$];

  int mismatches = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int long_frames_left = 2;
  bit sender_idles = 1'b1;
  bit sink_idles = 1'b1;
  bit hold_off_req = 1'b0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_BYTE,      8'h00,  0, '0},  // noise while hunting
    '{ROW_BYTE,      8'hAA, -1, '0},
    '{ROW_BYTE,      8'h00, -1, '0},
    '{ROW_BYTE,      8'h01, -1, '0},
    '{ROW_BYTE,      8'hFF, -1, '0},
    '{ROW_CRC_LO,    8'h00, -1, '0},
    '{ROW_CRC_HI,    8'h00,  1, '{8'h00, 7'd1, 6'd0, 8'hFF, 1'b1}},
    '{ROW_BYTE,      8'hAA, -1, '0},
    '{ROW_BYTE,      8'hFF, -1, '0},
    '{ROW_BYTE,      8'h00,  0, '0},  // zero length
    '{ROW_BYTE,      8'hAA, -1, '0},
    '{ROW_BYTE,      8'h05, -1, '0},
    '{ROW_BYTE,      8'hAA,  0, '0},  // too long, and must not restart the frame
    '{ROW_BYTE,      8'h03,  0, '0},
    '{ROW_BYTE,      8'h01,  0, '0},
    '{ROW_BYTE,      8'hAA, -1, '0},
    '{ROW_BYTE,      8'h12, -1, '0},
    '{ROW_BYTE,      8'h02, -1, '0},
    '{ROW_BYTE,      8'h00, -1, '0},
    '{ROW_BYTE,      8'h80, -1, '0},
    '{ROW_CRC_LO,    8'h00, -1, '0},
    '{ROW_CRC_BAD,   8'h00,  0, '0},  // bad checksum drops the frame
    '{ROW_SET_LIMIT, 8'h00, -1, '0},
    '{ROW_BYTE,      8'hAA, -1, '0},
    '{ROW_BYTE,      8'h01, -1, '0},
    '{ROW_BYTE,      8'h01,  0, '0}   // a zero limit rejects every length
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // CRC-16/CCITT-FALSE, one message bit at a time, MSB first.
  function automatic logic [15:0] crc16_shift_byte(input logic [15:0] crc,
                                                    input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic void restart_hunt();
    prs_phase    = PH_HUNT;
    prs_count    = '0;
    prs_crc_half = 1'b0;
    prs_id       = '0;
    prs_len      = '0;
    prs_crc      = CRC_INIT;
    prs_rx_crc   = '0;
  endfunction

  function automatic logic [6:0] length_limit();
    return (cfg_max < MAX_PAYLOAD) ? cfg_max : 7'(MAX_PAYLOAD);
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    payload_beat_t beat;
    int            i;
    case (prs_phase)
      PH_HUNT: begin
        if (b == cfg_start) begin
          restart_hunt();
          prs_crc   = crc16_shift_byte(CRC_INIT, b);
          prs_phase = PH_ID;
        end
      end
      PH_ID: begin
        prs_id    = b;
        prs_crc   = crc16_shift_byte(prs_crc, b);
        prs_phase = PH_LEN;
      end
      PH_LEN: begin
        if (b == 8'd0 || b > {1'b0, length_limit()}) begin
          restart_hunt();
        end else begin
          prs_len   = b[6:0];
          prs_crc   = crc16_shift_byte(prs_crc, b);
          prs_count = '0;
          prs_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        if (prs_count < MAX_PAYLOAD) prs_store[prs_count[5:0]] = b;
        prs_crc   = crc16_shift_byte(prs_crc, b);
        prs_count = prs_count + 7'd1;
        if (prs_count >= prs_len) begin
          prs_crc_half = 1'b0;
          prs_rx_crc   = '0;
          prs_phase    = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (!prs_crc_half) begin
          prs_rx_crc   = {8'h00, b};
          prs_crc_half = 1'b1;
        end else begin
          prs_rx_crc = prs_rx_crc | {b, 8'h00};
          if (prs_rx_crc == prs_crc) begin
            for (i = 0; i < prs_len && i < MAX_PAYLOAD; i++) begin
              beat.frame_id     = prs_id;
              beat.frame_length = prs_len;
              beat.byte_index   = 6'(i);
              beat.payload_byte = prs_store[i];
              beat.last_flag    = (i + 1 == prs_len);
              fresh_beats.push_back(beat);
            end
          end
          restart_hunt();
        end
      end
      default: restart_hunt();
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] expv,
                                 input logic [31:0] gotv);
    if (mismatches < MAX_PRINTS)
      $display("mismatch in %s: expected 0x%0h, got 0x%0h at %0t", what, expv, gotv,
               $time);
    mismatches++;
  endtask

  task automatic offer_byte(input logic [7:0] b, input int typed_n,
                            input payload_beat_t typed_beat);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_byte(b);
    items_sent++;
    if (typed_n < 0) begin
      foreach (fresh_beats[i]) awaited_beats.push_back(fresh_beats[i]);
    end else begin
      if (fresh_beats.size() != typed_n)
        report_mismatch("result count of a typed row", typed_n, fresh_beats.size());
      if (typed_n == 1) awaited_beats.push_back(typed_beat);
    end
    fresh_beats.delete();
  endtask

  task automatic sender_gap();
    int g;
    g = sender_idles ? pick_gap() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_item(input logic [7:0] b);
    sender_gap();
    offer_byte(b, -1, '0);
  endtask

  // Drops the input valid and waits for all pending results, then lets the
  // block finish any work that produces nothing.
  task automatic wait_for_idle(input int extra);
    s_axis_tvalid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_START_BYTE) cfg_start = v;
    else cfg_max = v[6:0];
  endtask

  // One frame, mostly well formed; a clean frame has no noise, no truncation, a correct
  // checksum and no bad length unless the length limit is zero.
  task automatic send_frame(input bit clean);
    logic [6:0]  lim;
    logic [15:0] crc;
    logic [7:0]  b;
    logic [7:0]  crc_lo;
    logic [7:0]  crc_hi;
    int          len;
    int          cut;
    int          r;
    lim = length_limit();
    r = $urandom_range(0, 99);
    if (!clean && r < 8) begin
      repeat ($urandom_range(1, 4)) send_item(8'($urandom));
      return;
    end
    r = $urandom_range(0, 99);
    if (lim == 0 || (!clean && r < 10)) begin
      len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(lim + 1, 255);
    end else if (!clean && r < 16 && (lim <= 16 || long_frames_left > 0)) begin
      len = lim;
      if (lim > 16) long_frames_left--;
    end else begin
      len = $urandom_range(1, (lim < 6) ? lim : 6);
    end
    cut = (!clean && $urandom_range(0, 99) < 5) ? $urandom_range(0, len - 1) : -1;

    crc = crc16_shift_byte(CRC_INIT, cfg_start);
    send_item(cfg_start);
    b = 8'($urandom);
    crc = crc16_shift_byte(crc, b);
    send_item(b);
    b = 8'(len);
    crc = crc16_shift_byte(crc, b);
    send_item(b);
    if (len == 0 || len > lim) return;
    for (int i = 0; i < len; i++) begin
      if (i == cut) return;
      b = 8'($urandom);
      crc = crc16_shift_byte(crc, b);
      send_item(b);
    end
    crc_lo = crc[7:0];
    crc_hi = crc[15:8];
    if (!clean && $urandom_range(0, 99) < 12) begin
      if ($urandom_range(0, 1) != 0) crc_lo = crc_lo ^ 8'($urandom_range(1, 255));
      else crc_hi = crc_hi ^ 8'($urandom_range(1, 255));
    end
    send_item(crc_lo);
    send_item(crc_hi);
  endtask

  // Output side: random back-pressure, plus one long hold-off on request.
  initial begin
    int g;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        g = sink_idles ? pick_gap() : 0;
        if (g > 0) begin
          m_axis_tready <= 1'b0;
          repeat (g) @(posedge clk_i);
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // Each request taken from the output is matched against the oldest
  // pending result.
  always @(posedge clk_i) begin
    payload_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_beats.size() == 0) begin
        report_mismatch("result with none pending", '0, m_axis_tdata);
      end else begin
        want = awaited_beats.pop_front();
        if (m_axis_tdata[7:0] !== want.frame_id)
          report_mismatch("frame_id", want.frame_id, m_axis_tdata[7:0]);
        if (m_axis_tdata[14:8] !== want.frame_length)
          report_mismatch("frame_length", want.frame_length, m_axis_tdata[14:8]);
        if (m_axis_tdata[20:15] !== want.byte_index)
          report_mismatch("byte_index", want.byte_index, m_axis_tdata[20:15]);
        if (m_axis_tdata[28:21] !== want.payload_byte)
          report_mismatch("payload_byte", want.payload_byte, m_axis_tdata[28:21]);
        if (m_axis_tdata[31:29] !== 3'b000)
          report_mismatch("tdata padding", '0, m_axis_tdata[31:29]);
        if (m_axis_tlast !== want.last_flag)
          report_mismatch("last", want.last_flag, m_axis_tlast);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    stim_row_t  row;
    logic [7:0] b;
    logic [7:0] new_start;
    logic [7:0] new_max;
    int         phase;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= '0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_start = 8'hAA;
    cfg_max   = 7'd64;
    restart_hunt();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_SET_LIMIT) begin
        wait_for_idle(SETTLE_CYCLES);
        write_reg(CFG_MAX_LENGTH, row.value);
      end else begin
        sender_gap();
        case (row.kind)
          ROW_CRC_LO:  b = prs_crc[7:0];
          ROW_CRC_HI:  b = prs_crc[15:8];
          ROW_CRC_BAD: b = prs_crc[15:8] ^ 8'h5A;
          default:     b = row.value;
        endcase
        offer_byte(b, row.typed_n, row.typed_beat);
      end
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_for_idle(SETTLE_CYCLES);
      case (phase)
        0: begin
          new_start = 8'h00;
          new_max   = 8'hFF;   // limit far above the payload capacity
        end
        1: begin
          new_start = 8'hFF;
          new_max   = 8'd1;
        end
        2: begin
          new_start = 8'hAA;
          new_max   = 8'd64;
        end
        3: begin
          new_start = 8'($urandom);
          new_max   = 8'd0;
        end
        default: begin
          new_start = 8'($urandom);
          new_max   = ($urandom_range(0, 99) < 75) ? 8'($urandom_range(1, 64))
                                                    : 8'($urandom_range(65, 127));
          new_max[7] = 1'($urandom);
        end
      endcase
      write_reg(CFG_START_BYTE, new_start);
      write_reg(CFG_MAX_LENGTH, new_max);
      sender_idles = ($urandom_range(0, 3) != 0);
      sink_idles   = ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        // Back-to-back short frames against a stalled output fill the queue.
        sender_idles = 1'b0;
        hold_off_req = 1'b1;
        repeat (10) send_frame(1'b1);
      end else begin
        repeat ($urandom_range(3, 6)) send_frame(1'b0);
      end
      // Sometimes leave a frame open so that the next register write lands
      // while the parser waits for its length byte.
      if ($urandom_range(0, 99) < 30) begin
        send_item(cfg_start);
        send_item(8'($urandom));
      end
      phase++;
    end

    wait_for_idle(DRAIN_CYCLES);
    if (mismatches == 0 && awaited_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/crc_rx_pkg.sv
rtl/crc_rx_ram.sv
rtl/crc_rx_front.sv
rtl/crc_rx_queue.sv
rtl/crc_rx_back.sv
rtl/crc_checked_frame_receiver_unit.sv
bench/tb_crc_checked_frame_receiver_unit.sv
